// File: design/icw_pkg.sv
// Shared types, sizes and codes for the inductor weighted calibration block.
// Used by every module under design/; depends on nothing.
package icw_pkg;

    // Block configuration.
    localparam int WINDOW_SAMPLES = 128;
    localparam int ADC_BITS       = 12;

    // Fixed algorithm constants.
    localparam int MIN_SAMPLES    = 20;
    localparam int MAX_SESSIONS   = 5;
    localparam int SEED_WEIGHT    = 50;

    // Field widths fixed by the interface.
    localparam int CAL_W  = 12;
    localparam int SESS_W = 3;
    localparam int CMD_W  = 1;

    // Derived datapath widths.
    localparam int ADC_MAX = (2 ** ADC_BITS) - 1;
    localparam int CAL_MAX = (2 ** CAL_W) - 1;
    localparam int CNT_W   = $clog2(WINDOW_SAMPLES + 1);
    localparam int ESUM_W  = $clog2(2 * ADC_MAX * WINDOW_SAMPLES + 1);
    localparam int MSUM_W  = $clog2(ADC_MAX * WINDOW_SAMPLES + 1);
    localparam int W_W     = $clog2(SEED_WEIGHT + MAX_SESSIONS * WINDOW_SAMPLES + 1);
    localparam int TOT_W   = $clog2(CAL_MAX * SEED_WEIGHT
                                    + MAX_SESSIONS * ADC_MAX * WINDOW_SAMPLES + 1);
    localparam int PROD_W  = ADC_BITS + CNT_W;

    // Shared divider: dividend is the widest total, divisor the weight.
    localparam int DIV_NW  = TOT_W;
    localparam int DIV_DW  = W_W;

    // Stream and register port sizes.
    localparam int S_DW    = 40;
    localparam int M_DW    = 32;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 32;

    // Input command codes.
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_FINISH = 1'b1;

    // Register indexes, decoded from paddr[2].
    localparam logic REG_EDGE_CAL_INIT = 1'b0;
    localparam logic REG_MID_CAL_INIT  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED,
        ST_CHECK,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_MUL,
        ST_ACC,
        ST_CLEAR,
        ST_REPORT
    } t_state;

    typedef enum logic [1:0] {
        DIV_EDGE_AVG,
        DIV_MID_AVG,
        DIV_EDGE_CAL,
        DIV_MID_CAL
    } t_div_sel;

    // Controller to datapath commands.
    typedef struct packed {
        logic     acc;
        logic     seed;
        logic     div_start;
        t_div_sel div_sel;
        logic     lat_q;
        logic     bump;
        logic     mul;
        logic     accum;
        logic     clear;
    } t_dp_cmd;

    // Datapath to controller and top-level status.
    typedef struct packed {
        logic              win_full;
        logic              tot_zero;
        logic              qualify;
        logic              div_done;
        logic [CAL_W-1:0]  edge_val;
        logic [CAL_W-1:0]  mid_val;
        logic [SESS_W-1:0] sess;
    } t_dp_sts;

    // Controller to top-level handshake control.
    typedef struct packed {
        logic ready;
        logic load;
        logic upd;
    } t_ctl_sts;

    // Register write as seen by the datapath.
    typedef struct packed {
        logic             wr;
        logic [CAL_W-1:0] edge_init;
        logic [CAL_W-1:0] mid_init;
    } t_cfg_wr;

endpackage

// File: design/inductor_weighted_calibration.sv
// Top level of the inductor weighted calibration block: stream ports,
// register port and output register. Depends on icw_pkg, icw_ctrl, icw_dp.
//
// Usage. Each input beat carries one left, right and middle inductor ADC
// reading and a command in tuser: a sample command adds the readings to
// the running session, a finish command ends the session. A sample command
// that arrives with the window of WINDOW_SAMPLES samples already full also
// ends the session, and its readings are dropped. Every input beat yields
// exactly one output beat with the current edge and middle calibration
// values, the number of sessions that have updated them, and in tuser a
// flag that is set when this beat ended a session that updated them.
// A sample beat's result is loaded into the output register from the report
// state that follows acceptance, and the next beat is taken back in idle. A
// session end passes the seed and check states; one that updates then runs
// four divisions through one shared restoring divider, one quotient bit per
// cycle over 22 bits, before the clear and report states; one that does not
// update goes from the check state straight to clear and report.
// The result sits in an output register, so a new beat is accepted while
// the previous result still waits; the block then holds that beat's result
// internally and stops taking input until the receiver frees the register.
// Reset clears all sums, totals and both registers, sets the weight to 50
// and the calibration values to zero. The two initial calibration values
// are written over the register port at byte addresses 0 and 4 while idle.
module inductor_weighted_calibration
    import icw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input stream.
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // tdata: left_adc [11:0], right_adc [23:12], middle_adc [35:24], zeros.
    input  logic [S_DW-1:0]   i_s_tdata,
    // tuser: cmd [0].
    input  logic [CMD_W-1:0]  i_s_tuser,
    // Result stream.
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // tdata: edge_cal [11:0], mid_cal [23:12], sessions_used [26:24], zeros.
    output logic [M_DW-1:0]   o_m_tdata,
    // tuser: updated [0].
    output logic              o_m_tuser,
    // Register port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    logic [CAL_W-1:0]  r_edge_init, n_edge_init;
    logic [CAL_W-1:0]  r_mid_init, n_mid_init;
    logic              r_m_valid;
    logic [CAL_W-1:0]  r_m_edge;
    logic [CAL_W-1:0]  r_m_mid;
    logic [SESS_W-1:0] r_m_sess;
    logic              r_m_upd;

    logic              w_cfg_wr;
    logic              w_accept;
    logic              w_out_free;
    t_cfg_wr           w_cfg;
    t_dp_cmd           w_cmd;
    t_dp_sts           w_sts;
    t_ctl_sts          w_ctl;

    // Register port: writes complete in the access phase, no wait states.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        n_edge_init = r_edge_init;
        n_mid_init  = r_mid_init;
        if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_EDGE_CAL_INIT: n_edge_init = pwdata[CAL_W-1:0];
                default:           n_mid_init  = pwdata[CAL_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_EDGE_CAL_INIT: prdata = CFG_DW'(r_edge_init);
            default:           prdata = CFG_DW'(r_mid_init);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_init <= '0;
            r_mid_init  <= '0;
        end else begin
            r_edge_init <= n_edge_init;
            r_mid_init  <= n_mid_init;
        end
    end

    // The datapath sees the register values as they stand after the write.
    assign w_cfg.wr        = w_cfg_wr;
    assign w_cfg.edge_init = n_edge_init;
    assign w_cfg.mid_init  = n_mid_init;

    // Input side: the controller takes a beat whenever it is idle.
    assign o_s_tready = w_ctl.ready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    // The output register can take a new result when empty or draining.
    assign w_out_free = !r_m_valid || i_m_tready;

    icw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_cmd      (i_s_tuser),
        .i_out_free (w_out_free),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_ctl      (w_ctl)
    );

    icw_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_cfg    (w_cfg),
        .i_left   (i_s_tdata[ADC_BITS-1:0]),
        .i_right  (i_s_tdata[CAL_W+ADC_BITS-1:CAL_W]),
        .i_middle (i_s_tdata[2*CAL_W+ADC_BITS-1:2*CAL_W]),
        .o_sts    (w_sts)
    );

    // Output register, loaded when the controller reports a finished beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_ctl.load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.load) begin
            r_m_edge <= w_sts.edge_val;
            r_m_mid  <= w_sts.mid_val;
            r_m_sess <= w_sts.sess;
            r_m_upd  <= w_ctl.upd;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {(M_DW - 2 * CAL_W - SESS_W)'(0), r_m_sess, r_m_mid, r_m_edge};
    assign o_m_tuser  = r_m_upd;

endmodule

// File: design/icw_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on icw_pkg for the dividend and divisor widths.
module icw_div
    import icw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_dividend,
    input  logic [DIV_DW-1:0] i_divisor,
    output logic              o_done,
    output logic [DIV_NW-1:0] o_quotient
);

    localparam int STEP_W = $clog2(DIV_NW);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW-1:0] r_dsr;

    logic [DIV_DW:0]   w_shift;
    logic [DIV_DW:0]   w_diff;
    logic              w_ge;

    assign w_shift = {r_rem, r_quo[DIV_NW-1]};
    assign w_diff  = w_shift - {1'b0, r_dsr};
    assign w_ge    = (w_shift >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == STEP_W'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIV_DW-1:0] : w_shift[DIV_DW-1:0];
            r_quo <= {r_quo[DIV_NW-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: design/icw_dp.sv
// Datapath: session sums, weighted totals, weight and calibration values,
// with the shared divider. Depends on icw_pkg and icw_div.
module icw_dp
    import icw_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  t_cfg_wr             i_cfg,
    input  logic [ADC_BITS-1:0] i_left,
    input  logic [ADC_BITS-1:0] i_right,
    input  logic [ADC_BITS-1:0] i_middle,
    output t_dp_sts             o_sts
);

    logic [CNT_W-1:0]    r_count;
    logic [ESUM_W-1:0]   r_esum;
    logic [MSUM_W-1:0]   r_msum;
    logic [SESS_W-1:0]   r_sess;
    logic [TOT_W-1:0]    r_wet;
    logic [TOT_W-1:0]    r_wmt;
    logic [W_W-1:0]      r_weight;
    logic [CAL_W-1:0]    r_ev;
    logic [CAL_W-1:0]    r_mv;
    logic [ADC_BITS-1:0] r_eavg;
    logic [ADC_BITS-1:0] r_mavg;
    logic [PROD_W-1:0]   r_eprod;
    logic [PROD_W-1:0]   r_mprod;

    logic [CAL_W+W_W-1:0] w_seed_e;
    logic [CAL_W+W_W-1:0] w_seed_m;
    logic [PROD_W-1:0]    w_eprod;
    logic [PROD_W-1:0]    w_mprod;
    logic [DIV_NW-1:0]    w_dividend;
    logic [DIV_DW-1:0]    w_divisor;
    logic                 w_div_done;
    logic [DIV_NW-1:0]    w_quo;

    assign w_seed_e = (CAL_W + W_W)'(r_ev) * (CAL_W + W_W)'(r_weight);
    assign w_seed_m = (CAL_W + W_W)'(r_mv) * (CAL_W + W_W)'(r_weight);
    assign w_eprod  = PROD_W'(r_eavg) * PROD_W'(r_count);
    assign w_mprod  = PROD_W'(r_mavg) * PROD_W'(r_count);

    always_comb begin
        unique case (i_cmd.div_sel)
            DIV_EDGE_AVG: begin
                w_dividend = DIV_NW'(r_esum);
                w_divisor  = DIV_DW'(r_count);
            end
            DIV_MID_AVG: begin
                w_dividend = DIV_NW'(r_msum);
                w_divisor  = DIV_DW'(r_count);
            end
            DIV_EDGE_CAL: begin
                w_dividend = r_wet;
                w_divisor  = r_weight;
            end
            default: begin
                w_dividend = r_wmt;
                w_divisor  = r_weight;
            end
        endcase
    end

    icw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // Architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_esum   <= '0;
            r_msum   <= '0;
            r_sess   <= '0;
            r_wet    <= '0;
            r_wmt    <= '0;
            r_weight <= W_W'(SEED_WEIGHT);
            r_ev     <= '0;
            r_mv     <= '0;
        end else begin
            if (i_cfg.wr && (r_sess == '0)) begin
                r_ev  <= i_cfg.edge_init;
                r_mv  <= i_cfg.mid_init;
                r_wet <= '0;
                r_wmt <= '0;
            end
            if (i_cmd.acc) begin
                r_count <= r_count + 1'b1;
                r_esum  <= r_esum + ESUM_W'(i_left) + ESUM_W'(i_right);
                r_msum  <= r_msum + MSUM_W'(i_middle);
            end
            if (i_cmd.seed) begin
                r_wet <= TOT_W'(w_seed_e);
                r_wmt <= TOT_W'(w_seed_m);
            end
            if (i_cmd.accum) begin
                r_wet    <= r_wet + TOT_W'(r_eprod);
                r_wmt    <= r_wmt + TOT_W'(r_mprod);
                r_weight <= r_weight + W_W'(r_count);
            end
            if (i_cmd.lat_q && (i_cmd.div_sel == DIV_EDGE_CAL)) begin
                r_ev <= w_quo[CAL_W-1:0];
            end
            if (i_cmd.lat_q && (i_cmd.div_sel == DIV_MID_CAL)) begin
                r_mv <= w_quo[CAL_W-1:0];
            end
            if (i_cmd.bump) begin
                r_sess <= r_sess + 1'b1;
            end
            if (i_cmd.clear) begin
                r_count <= '0;
                r_esum  <= '0;
                r_msum  <= '0;
            end
        end
    end

    // Intermediate averages and products of one session end.
    always_ff @(posedge i_clk) begin
        if (i_cmd.lat_q && (i_cmd.div_sel == DIV_EDGE_AVG)) begin
            r_eavg <= w_quo[ADC_BITS:1];
        end
        if (i_cmd.lat_q && (i_cmd.div_sel == DIV_MID_AVG)) begin
            r_mavg <= w_quo[ADC_BITS-1:0];
        end
        if (i_cmd.mul) begin
            r_eprod <= w_eprod;
            r_mprod <= w_mprod;
        end
    end

    assign o_sts.win_full = (r_count == CNT_W'(WINDOW_SAMPLES));
    assign o_sts.tot_zero = (r_wet == '0) && (r_wmt == '0);
    assign o_sts.qualify  = (r_count > CNT_W'(MIN_SAMPLES))
                         && (r_sess < SESS_W'(MAX_SESSIONS));
    assign o_sts.div_done = w_div_done;
    assign o_sts.edge_val = r_ev;
    assign o_sts.mid_val  = r_mv;
    assign o_sts.sess     = r_sess;

endmodule

// File: design/icw_ctrl.sv
// Controller state machine: sequences sample accumulation and the session
// end steps over the datapath. Depends on icw_pkg.
module icw_ctrl
    import icw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [CMD_W-1:0] i_cmd,
    input  logic             i_out_free,
    input  t_dp_sts          i_sts,
    output t_dp_cmd          o_cmd,
    output t_ctl_sts         o_ctl
);

    t_state   r_state, n_state;
    t_div_sel r_div_sel, n_div_sel;
    logic     r_upd, n_upd;
    logic     w_sample;

    assign w_sample = (i_cmd == CMD_SAMPLE) && !i_sts.win_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_div_sel <= DIV_EDGE_AVG;
            r_upd     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_div_sel <= n_div_sel;
            r_upd     <= n_upd;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_div_sel = r_div_sel;
        n_upd     = r_upd;
        unique case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    n_upd   = 1'b0;
                    n_state = w_sample ? ST_REPORT : ST_SEED;
                end
            end
            ST_SEED: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_sts.qualify) begin
                    n_div_sel = DIV_EDGE_AVG;
                    n_state   = ST_DIV_START;
                end else begin
                    n_state = ST_CLEAR;
                end
            end
            ST_DIV_START: begin
                n_state = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    unique case (r_div_sel)
                        DIV_EDGE_AVG: begin
                            n_div_sel = DIV_MID_AVG;
                            n_state   = ST_DIV_START;
                        end
                        DIV_MID_AVG: begin
                            n_state = ST_MUL;
                        end
                        DIV_EDGE_CAL: begin
                            n_div_sel = DIV_MID_CAL;
                            n_state   = ST_DIV_START;
                        end
                        default: begin
                            n_upd   = 1'b1;
                            n_state = ST_CLEAR;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                n_div_sel = DIV_EDGE_CAL;
                n_state   = ST_DIV_START;
            end
            ST_CLEAR: begin
                n_state = ST_REPORT;
            end
            ST_REPORT: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.div_sel = r_div_sel;
        o_ctl         = '0;
        o_ctl.upd     = r_upd;
        unique case (r_state)
            ST_IDLE: begin
                o_ctl.ready = 1'b1;
                o_cmd.acc   = i_accept && w_sample;
            end
            ST_SEED: begin
                o_cmd.seed = i_sts.tot_zero;
            end
            ST_DIV_START: begin
                o_cmd.div_start = 1'b1;
            end
            ST_DIV_WAIT: begin
                o_cmd.lat_q = i_sts.div_done;
                o_cmd.bump  = i_sts.div_done && (r_div_sel == DIV_MID_CAL);
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
            end
            ST_ACC: begin
                o_cmd.accum = 1'b1;
            end
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            ST_REPORT: begin
                o_ctl.load = i_out_free;
            end
            default: begin
                o_cmd.clear = 1'b0;
            end
        endcase
    end

endmodule

// File: test/tb_inductor_weighted_calibration.sv
// Self-checking testbench for inductor_weighted_calibration: stream and APB stimulus,
// an in-bench predictor of the calibration sums and totals, and a scoreboard of results.
// Depends on icw_pkg and the RTL under design/ only.
module tb_inductor_weighted_calibration;
    timeunit 1ns;
    timeprecision 1ps;
    import icw_pkg::*;

    // Run length and safety limits.
    localparam int RANDOM_BEATS = 500;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int TAIL_CYCLES  = 150;
    localparam int HOLD_CYCLES  = 400;

    // One expected or observed result beat, unpacked into its fields.
    typedef struct packed {
        logic [CAL_W-1:0]  edge_cal;
        logic [CAL_W-1:0]  mid_cal;
        logic              updated;
        logic [SESS_W-1:0] sessions;
    } t_cal_result;

    localparam t_cal_result RES_ZERO     = '{12'h000, 12'h000, 1'b0, 3'd0};
    localparam t_cal_result RES_FULL     = '{12'hFFF, 12'hFFF, 1'b0, 3'd0};
    localparam t_cal_result RES_MID_ONLY = '{12'h000, 12'hFFF, 1'b0, 3'd0};

    // A directed row is either an input beat or a register write. For a write,
    // the register value travels in the left field.
    typedef enum logic {ROW_BEAT, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic [CMD_W-1:0] cmd;
        logic             reg_idx;
        logic [11:0]      left;
        logic [11:0]      right;
        logic [11:0]      middle;
        logic             typed;
        t_cal_result      want;
    } t_dir_row;

    typedef enum logic [1:0] {SESS_EMPTY, SESS_SHORT, SESS_LONG, SESS_WINDOW} t_session_kind;

    // Directed part. Before any session has updated, the outputs simply mirror the
    // initial registers, so those rows carry their expected result; the rest go
    // through the predictor.
    localparam int DIR_ROWS = 14;
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        // Finish with nothing held, then a short session, all at reset values.
        '{ROW_BEAT,  CMD_FINISH, 1'b0, 12'h000, 12'h000, 12'h000, 1'b1, RES_ZERO},
        '{ROW_BEAT,  CMD_SAMPLE, 1'b0, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1, RES_ZERO},
        '{ROW_BEAT,  CMD_SAMPLE, 1'b0, 12'h000, 12'h000, 12'h000, 1'b1, RES_ZERO},
        '{ROW_BEAT,  CMD_FINISH, 1'b0, 12'h000, 12'h000, 12'h000, 1'b1, RES_ZERO},
        // Both initial values at their top, loaded before the first update.
        '{ROW_WRITE, CMD_SAMPLE, REG_EDGE_CAL_INIT, 12'hFFF, 12'h000, 12'h000, 1'b0, RES_ZERO},
        '{ROW_WRITE, CMD_SAMPLE, REG_MID_CAL_INIT,  12'hFFF, 12'h000, 12'h000, 1'b0, RES_ZERO},
        '{ROW_BEAT,  CMD_SAMPLE, 1'b0, 12'hFFF, 12'h000, 12'hFFF, 1'b1, RES_FULL},
        '{ROW_BEAT,  CMD_SAMPLE, 1'b0, 12'h000, 12'hFFF, 12'h000, 1'b1, RES_FULL},
        // Short session: seeds the totals from the loaded values, no update.
        '{ROW_BEAT,  CMD_FINISH, 1'b0, 12'h000, 12'h000, 12'h000, 1'b1, RES_FULL},
        // A later write reloads the values and clears the seeded totals.
        '{ROW_WRITE, CMD_SAMPLE, REG_EDGE_CAL_INIT, 12'h000, 12'h000, 12'h000, 1'b0, RES_ZERO},
        '{ROW_BEAT,  CMD_FINISH, 1'b0, 12'h000, 12'h000, 12'h000, 1'b1, RES_MID_ONLY},
        '{ROW_WRITE, CMD_SAMPLE, REG_MID_CAL_INIT,  12'h5A3, 12'h000, 12'h000, 1'b0, RES_ZERO},
        '{ROW_BEAT,  CMD_SAMPLE, 1'b0, 12'hA5A, 12'h5A5, 12'hA5A, 1'b0, RES_ZERO},
        '{ROW_BEAT,  CMD_FINISH, 1'b0, 12'h000, 12'h000, 12'h000, 1'b0, RES_ZERO}
    };

    // Block ports. Every input has a known value from time zero.
    logic              i_clk;
    logic              i_rst_n   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              o_s_tready;
    logic [S_DW-1:0]   s_tdata   = '0;
    logic [CMD_W-1:0]  s_tuser   = CMD_SAMPLE;
    logic              o_m_tvalid;
    logic              m_tready  = 1'b0;
    logic [M_DW-1:0]   o_m_tdata;
    logic              o_m_tuser;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [CFG_AW-1:0] paddr     = '0;
    logic [CFG_DW-1:0] pwdata    = '0;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    inductor_weighted_calibration u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Predictor state: a private copy of the block's sums, totals and registers.
    logic [CNT_W-1:0]  p_count;
    logic [ESUM_W-1:0] p_edge_sum;
    logic [MSUM_W-1:0] p_mid_sum;
    logic [SESS_W-1:0] p_sessions;
    logic [TOT_W-1:0]  p_edge_total;
    logic [TOT_W-1:0]  p_mid_total;
    logic [W_W-1:0]    p_weight;
    logic [CAL_W-1:0]  p_edge_val;
    logic [CAL_W-1:0]  p_mid_val;
    logic [CAL_W-1:0]  p_edge_init;
    logic [CAL_W-1:0]  p_mid_init;

    // Results still owed by the block, oldest first.
    t_cal_result cal_results_due [$];

    int errors         = 0;
    int beats_sent     = 0;
    int results_seen   = 0;
    int updates_seen   = 0;
    int writes_done    = 0;
    int windows_filled = 0;
    int cycle_count    = 0;
    int burst_left     = 0;

    // Receiver-side state, owned by the receiver process alone.
    logic hold_off_req  = 1'b0;
    logic hold_off_done = 1'b0;
    int   hold_left     = 0;
    int   rx_mode       = 0;
    int   rx_mode_left  = 0;
    int   rx_phase      = 0;
    t_cal_result rx_got;
    t_cal_result rx_want;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results still due", $time, cal_results_due.size());
            $display("[inductor_weighted_calibration] ERROR");
            $finish;
        end
    end

    // Advances the predictor by one accepted input beat and returns the result
    // the block must produce for it. A sample on a full window, or a finish,
    // closes the session; the closing beat's readings never enter the sums.
    function automatic t_cal_result predict_calibration(input logic [CMD_W-1:0] cmd,
                                                        input logic [11:0] left,
                                                        input logic [11:0] right,
                                                        input logic [11:0] middle);
        t_cal_result       res;
        logic              upd;
        longint unsigned   edge_avg;
        longint unsigned   mid_avg;
        upd = 1'b0;
        if (cmd == CMD_SAMPLE && p_count < WINDOW_SAMPLES) begin
            p_count    = p_count + CNT_W'(1);
            p_edge_sum = p_edge_sum + ESUM_W'(left) + ESUM_W'(right);
            p_mid_sum  = p_mid_sum + MSUM_W'(middle);
        end else begin
            // Totals are seeded once, or again after a write has cleared them.
            if (p_edge_total == 0 && p_mid_total == 0) begin
                p_edge_total = TOT_W'(p_edge_val) * TOT_W'(p_weight);
                p_mid_total  = TOT_W'(p_mid_val) * TOT_W'(p_weight);
            end
            if (p_count > MIN_SAMPLES && p_sessions < MAX_SESSIONS) begin
                // The edge average covers two coils, hence the extra halving.
                edge_avg     = 64'(p_edge_sum) / 64'(p_count) / 64'd2;
                mid_avg      = 64'(p_mid_sum) / 64'(p_count);
                p_sessions   = p_sessions + SESS_W'(1);
                p_edge_total = TOT_W'(64'(p_edge_total) + edge_avg * 64'(p_count));
                p_mid_total  = TOT_W'(64'(p_mid_total) + mid_avg * 64'(p_count));
                p_weight     = p_weight + W_W'(p_count);
                p_edge_val   = CAL_W'(p_edge_total / TOT_W'(p_weight));
                p_mid_val    = CAL_W'(p_mid_total / TOT_W'(p_weight));
                upd          = 1'b1;
            end
            p_edge_sum = '0;
            p_mid_sum  = '0;
            p_count    = '0;
        end
        res.edge_cal = p_edge_val;
        res.mid_cal  = p_mid_val;
        res.updated  = upd;
        res.sessions = p_sessions;
        return res;
    endfunction

    // A register write reaches the live values only until the first update.
    function automatic void apply_cal_init_write(input logic idx, input logic [CAL_W-1:0] val);
        if (idx == REG_EDGE_CAL_INIT) begin
            p_edge_init = val;
        end else begin
            p_mid_init = val;
        end
        if (p_sessions == 0) begin
            p_edge_val   = p_edge_init;
            p_mid_val    = p_mid_init;
            p_edge_total = '0;
            p_mid_total  = '0;
        end
    endfunction

    // Readings and register values: extremes now and then, mostly uniform.
    function automatic logic [11:0] pick_reading();
        case ($urandom_range(0, 7))
            0: return 12'h000;
            1: return 12'hFFF;
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    // Offers one beat, waits for the handshake, records the owed result and
    // then either keeps the burst going or drops tvalid for a random gap.
    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [11:0] left,
                             input logic [11:0] right, input logic [11:0] middle,
                             input logic typed, input t_cal_result want);
        t_cal_result pred;
        int          r;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DW - 36){1'b0}}, middle, right, left};
        s_tuser  <= cmd;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pred = predict_calibration(cmd, left, right, middle);
        cal_results_due.push_back(typed ? want : pred);
        beats_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 20);
            r = $urandom_range(0, 9);
            s_tvalid <= 1'b0;
            // Mostly short gaps, sometimes long enough to span a whole session close.
            if (r < 6) begin
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else if (r < 9) begin
                repeat ($urandom_range(5, 30)) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(60, 150)) @(posedge i_clk);
            end
        end
    endtask

    // Stops offering and waits until every owed result has come back; since
    // each beat yields exactly one result, the block is idle afterwards.
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (cal_results_due.size() != 0) @(posedge i_clk);
    endtask

    // APB write of one initial calibration value, then a read back of it.
    task automatic write_cal_init(input logic idx, input logic [CAL_W-1:0] val);
        logic [CFG_DW-1:0] rd;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(CFG_DW - CAL_W){1'b0}}, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        apply_cal_init_write(idx, val);
        writes_done++;
        // Back-to-back read of the same register: new setup phase, psel held.
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== {{(CFG_DW - CAL_W){1'b0}}, val}) begin
            $display("%0t: register %0d read back, expected %0d, got %0d",
                     $time, idx, val, rd);
            errors++;
        end
    endtask

    // Receiver: checks every accepted result against the oldest one owed, and
    // drives tready on a stall pattern that changes mode every so often. Once
    // asked, it holds off for a long stretch so that the block backs up.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && m_tready) begin
            rx_got.edge_cal = o_m_tdata[11:0];
            rx_got.mid_cal  = o_m_tdata[23:12];
            rx_got.sessions = o_m_tdata[26:24];
            rx_got.updated  = o_m_tuser;
            results_seen++;
            if (rx_got.updated) updates_seen++;
            if (cal_results_due.size() == 0) begin
                $display("%0t: result beat with none expected, got %h", $time, rx_got);
                errors++;
            end else begin
                rx_want = cal_results_due.pop_front();
                if (rx_got.edge_cal !== rx_want.edge_cal) begin
                    $display("%0t: edge_cal expected %0d, got %0d",
                             $time, rx_want.edge_cal, rx_got.edge_cal);
                    errors++;
                end
                if (rx_got.mid_cal !== rx_want.mid_cal) begin
                    $display("%0t: mid_cal expected %0d, got %0d",
                             $time, rx_want.mid_cal, rx_got.mid_cal);
                    errors++;
                end
                if (rx_got.updated !== rx_want.updated) begin
                    $display("%0t: updated expected %0d, got %0d",
                             $time, rx_want.updated, rx_got.updated);
                    errors++;
                end
                if (rx_got.sessions !== rx_want.sessions) begin
                    $display("%0t: sessions_used expected %0d, got %0d",
                             $time, rx_want.sessions, rx_got.sessions);
                    errors++;
                end
            end
        end

        if (hold_off_req && !hold_off_done) begin
            hold_left     = HOLD_CYCLES;
            hold_off_done = 1'b1;
        end
        rx_phase++;
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(20, 200);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= (rx_phase % 4 == 0);
                default: m_tready <= (rx_phase % 8 != 7);
            endcase
        end
    end

    // Main sequence: reset, directed table, then random sessions with register
    // phases in between, and finally the drain and the verdict.
    initial begin
        int            n;
        int            r;
        int            start_beats;
        t_session_kind kind;

        p_count      = '0;
        p_edge_sum   = '0;
        p_mid_sum    = '0;
        p_sessions   = '0;
        p_edge_total = '0;
        p_mid_total  = '0;
        p_weight     = W_W'(SEED_WEIGHT);
        p_edge_val   = '0;
        p_mid_val    = '0;
        p_edge_init  = '0;
        p_mid_init   = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows. Register writes only ever happen on an idle block.
        for (int i = 0; i < DIR_ROWS; i++) begin
            if (DIR_TABLE[i].kind == ROW_WRITE) begin
                wait_results_drained();
                write_cal_init(DIR_TABLE[i].reg_idx, DIR_TABLE[i].left);
            end else begin
                send_beat(DIR_TABLE[i].cmd, DIR_TABLE[i].left, DIR_TABLE[i].right,
                          DIR_TABLE[i].middle, DIR_TABLE[i].typed, DIR_TABLE[i].want);
            end
        end

        // Random sessions. The first few stay short so that register writes
        // still reload the live values; the seventh fills the window and runs
        // under the long receiver hold-off. After that most sessions are long
        // enough to update, until the session limit makes the block ignore them.
        start_beats = beats_sent;
        for (int s = 0; beats_sent - start_beats < RANDOM_BEATS; s++) begin
            if (s < 6 || $urandom_range(0, 4) == 0) begin
                wait_results_drained();
                if ($urandom_range(0, 1) == 1) begin
                    write_cal_init(REG_EDGE_CAL_INIT, pick_reading());
                    write_cal_init(REG_MID_CAL_INIT, pick_reading());
                end else begin
                    write_cal_init(1'($urandom_range(0, 1)), pick_reading());
                end
            end

            if (s == 6) begin
                hold_off_req <= 1'b1;
                kind = SESS_WINDOW;
            end else if (s < 6) begin
                kind = ($urandom_range(0, 2) == 0) ? SESS_EMPTY : SESS_SHORT;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 10) kind = SESS_EMPTY;
                else if (r < 35) kind = SESS_SHORT;
                else if (r < 80) kind = SESS_LONG;
                else kind = SESS_WINDOW;
            end

            case (kind)
                SESS_EMPTY: n = 0;
                // Exactly twenty samples is the largest session that is discarded.
                SESS_SHORT: n = ($urandom_range(0, 2) == 0) ? MIN_SAMPLES
                                                            : $urandom_range(1, MIN_SAMPLES);
                SESS_LONG:  n = $urandom_range(MIN_SAMPLES + 1, 60);
                default:    n = WINDOW_SAMPLES;
            endcase
            for (int k = 0; k < n; k++) begin
                send_beat(CMD_SAMPLE, pick_reading(), pick_reading(), pick_reading(),
                          1'b0, RES_ZERO);
            end
            // A full window is closed either by a finish or by one more sample,
            // whose readings are dropped.
            if (kind == SESS_WINDOW) windows_filled++;
            if (kind == SESS_WINDOW && $urandom_range(0, 1) == 1) begin
                send_beat(CMD_SAMPLE, pick_reading(), pick_reading(), pick_reading(),
                          1'b0, RES_ZERO);
            end else begin
                send_beat(CMD_FINISH, pick_reading(), pick_reading(), pick_reading(),
                          1'b0, RES_ZERO);
            end
        end

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Summary: %0d input beats, %0d result beats checked, %0d updating sessions,",
                 beats_sent, results_seen, updates_seen);
        $display("         %0d register writes, %0d full windows, %0d mismatches.",
                 writes_done, windows_filled, errors);
        if (errors == 0) begin
            $display("[inductor_weighted_calibration] OK");
        end else begin
            $display("[inductor_weighted_calibration] ERROR");
        end
        $finish;
    end

endmodule
